@@ hw/rtl/lcm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and constants of the laser color mixer.
// ----------------------------------------------------------------------------
package lcm_pkg;

	localparam int unsigned COLOR_W = 8;
	localparam int unsigned MIX_W   = 10;  // half units, up to 1020
	localparam int unsigned GAIN_W  = 12;  // unsigned Q4.8
	localparam int unsigned RATIO_W = 9;
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned PROD_W  = MIX_W + GAIN_W;  // 22
	localparam int unsigned SUB_W   = 21;              // signed (256-ratio)*max
	localparam int unsigned VAL_W   = 24;              // signed channel value
	localparam int unsigned WLUM_W  = 35;              // signed weighted channel
	localparam int unsigned LUMA_W  = 36;              // signed luma sum
	localparam int unsigned Q1_W    = 18;              // luma / 512 below saturation
	localparam int unsigned RECIP_W = 19;
	localparam int unsigned QPROD_W = Q1_W + RECIP_W;

	// floor(x/1000) == (x * RECIP_1000) >> RECIP_SHIFT for x below 2^18.
	localparam logic [RECIP_W-1:0] RECIP_1000  = 19'd268436;
	localparam int unsigned        RECIP_SHIFT = 28;

	localparam logic [VAL_W-1:0]  CH_SAT   = 24'd131072;      // 256 * 512
	localparam logic [LUMA_W-1:0] LUMA_SAT = 36'd131072000;   // 256 * 512000

	localparam logic [2:0] CH_RED   = 3'b001;
	localparam logic [2:0] CH_GREEN = 3'b010;
	localparam logic [2:0] CH_BLUE  = 3'b100;

	localparam logic [COLOR_W-1:0] LEVEL_MAX = 8'hFF;
	localparam logic [COLOR_W-1:0] LEVEL_MIN = 8'h00;

	typedef enum logic [IDX_W-1:0] {
		REG_CHANNEL_ENABLE = 3'd0,
		REG_ANALOG_MODE    = 3'd1,
		REG_LEVEL_RATIO    = 3'd2,
		REG_GAIN_RED       = 3'd3,
		REG_GAIN_GREEN     = 3'd4,
		REG_GAIN_BLUE      = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [2:0]         channel_enable;
		logic               analog_mode;
		logic [RATIO_W-1:0] level_ratio;
		logic [GAIN_W-1:0]  gain_red;
		logic [GAIN_W-1:0]  gain_green;
		logic [GAIN_W-1:0]  gain_blue;
	} cfg_t;

	typedef struct packed {
		logic [MIX_W-1:0] red;
		logic [MIX_W-1:0] green;
		logic [MIX_W-1:0] blue;
	} mix_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] red;
		logic signed [VAL_W-1:0] green;
		logic signed [VAL_W-1:0] blue;
	} val_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} level_t;

endpackage

@@ hw/rtl/lcm_pt_if.sv @@
// ----------------------------------------------------------------------------
// lcm_pt_if
// Point color channel: one RGB point per beat.
// ----------------------------------------------------------------------------
interface lcm_pt_if import lcm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] in_red;
	logic [COLOR_W-1:0] in_green;
	logic [COLOR_W-1:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

@@ hw/rtl/lcm_lvl_if.sv @@
// ----------------------------------------------------------------------------
// lcm_lvl_if
// Drive level channel: red, green, blue and gray levels per beat.
// ----------------------------------------------------------------------------
interface lcm_lvl_if import lcm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] out_red;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_blue;
	logic [COLOR_W-1:0] out_gray;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_gray, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_gray, output ready);
endinterface

@@ hw/rtl/lcm_cfg.sv @@
// ----------------------------------------------------------------------------
// lcm_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lcm_cfg import lcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_enable <= CH_RED | CH_GREEN | CH_BLUE;
			cfg_q.analog_mode    <= 1'b1;
			cfg_q.level_ratio    <= 9'd256;
			cfg_q.gain_red       <= 12'd256;
			cfg_q.gain_green     <= 12'd256;
			cfg_q.gain_blue      <= 12'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_ENABLE: cfg_q.channel_enable <= cfg_data[2:0];
				REG_ANALOG_MODE:    cfg_q.analog_mode    <= cfg_data[0];
				REG_LEVEL_RATIO:    cfg_q.level_ratio    <= cfg_data[RATIO_W-1:0];
				REG_GAIN_RED:       cfg_q.gain_red       <= cfg_data[GAIN_W-1:0];
				REG_GAIN_GREEN:     cfg_q.gain_green     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_BLUE:      cfg_q.gain_blue      <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

@@ hw/rtl/laser_color_mixer.sv @@
// ----------------------------------------------------------------------------
// laser_color_mixer
// Per-point laser color mixing with channel folding, level ratio and luma.
// ----------------------------------------------------------------------------
// Points arrive on the points channel (valid/ready, one RGB point per beat)
// and leave on the levels channel as red, green, blue and gray drive levels.
// Registers are written through cfg_we/cfg_index/cfg_data; write them only
// while no point is in flight.
// The datapath is a seven-stage pipeline: fold, products, channel values,
// luma weights, luma sum, level and reciprocal product, gray level. A point
// accepted on the points channel passes through the stage registers in order
// and is offered on the levels channel from the gray level stage register.
// One point is accepted every cycle while no stall holds the pipeline; each
// point makes a single pass through the stages.
// Every stage has its own valid bit and stalls only when it is full and the
// stage after it cannot take its beat, so bubbles close up and a stalled
// receiver fills the pipeline before points.ready falls; the final level
// beat holds steady until taken.
// Reset clears every valid bit and loads the register reset values: all
// channels enabled, analog mode, ratio 1.0 and unity gains.
// ----------------------------------------------------------------------------
module laser_color_mixer import lcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	lcm_pt_if.sink           points,
	lcm_lvl_if.source        levels,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	cfg_t cfg;

	lcm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	assign en_s7 = !vld_s7 || levels.ready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign points.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= points.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: fold disabled channels into the enabled ones, in half units.
	logic [MIX_W-1:0] r1, g1, b1;
	mix_t             mix_d;
	mix_t             mix_s1;

	assign r1 = MIX_W'(points.in_red);
	assign g1 = MIX_W'(points.in_green);
	assign b1 = MIX_W'(points.in_blue);

	always_comb begin
		mix_d = '0;
		case (cfg.channel_enable)
			CH_RED:   mix_d.red   = (r1 << 1) + g1 + b1;
			CH_GREEN: mix_d.green = r1 + (g1 << 1) + b1;
			CH_BLUE:  mix_d.blue  = r1 + g1 + (b1 << 1);
			CH_RED | CH_GREEN: begin
				mix_d.red   = (r1 << 1) + b1;
				mix_d.green = (g1 << 1) + b1;
			end
			CH_RED | CH_BLUE: begin
				mix_d.red  = (r1 << 1) + g1;
				mix_d.blue = (b1 << 1) + g1;
			end
			CH_GREEN | CH_BLUE: begin
				mix_d.green = (g1 << 1) + r1;
				mix_d.blue  = (b1 << 1) + r1;
			end
			CH_RED | CH_GREEN | CH_BLUE: begin
				mix_d.red   = r1 << 1;
				mix_d.green = g1 << 1;
				mix_d.blue  = b1 << 1;
			end
			default: mix_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1) mix_s1 <= mix_d;
	end

	// Stage 2: gain products and the brightness term.
	logic        [MIX_W-1:0]  mx;
	logic signed [MIX_W-1:0]  ratio_k;
	logic        [PROD_W-1:0] pr_s2, pg_s2, pb_s2;
	logic signed [SUB_W-1:0]  sub_s2;

	always_comb begin
		mx = mix_s1.red;
		if (mix_s1.blue > mx) mx = mix_s1.blue;
		if (mix_s1.green > mx) mx = mix_s1.green;
	end

	// 256 - ratio wraps correctly in ten bits for every ratio code.
	assign ratio_k = $signed(MIX_W'(10'd256 - {1'b0, cfg.level_ratio}));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pr_s2  <= mix_s1.red * cfg.gain_red;
			pg_s2  <= mix_s1.green * cfg.gain_green;
			pb_s2  <= mix_s1.blue * cfg.gain_blue;
			sub_s2 <= SUB_W'(ratio_k * $signed({1'b0, mx}));
		end
	end

	// Stage 3: channel values, real value is v / 512.
	val_t val_s3, val_s4, val_s5;
	logic signed [VAL_W-1:0] sub_ext;

	assign sub_ext = VAL_W'(sub_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			val_s3.red   <= $signed(VAL_W'(pr_s2)) - sub_ext;
			val_s3.green <= $signed(VAL_W'(pg_s2)) - sub_ext;
			val_s3.blue  <= $signed(VAL_W'(pb_s2)) - sub_ext;
		end
	end

	// Stage 4: luma weights.
	logic signed [WLUM_W-1:0] wr_s4, wg_s4, wb_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			wr_s4  <= WLUM_W'(val_s3.red * 11'sd299);
			wg_s4  <= WLUM_W'(val_s3.green * 11'sd587);
			wb_s4  <= WLUM_W'(val_s3.blue * 11'sd114);
			val_s4 <= val_s3;
		end
	end

	// Stage 5: luma sum, real value is luma / 512000.
	logic signed [LUMA_W-1:0] luma_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			luma_s5 <= LUMA_W'(wr_s4) + LUMA_W'(wg_s4) + LUMA_W'(wb_s4);
			val_s5  <= val_s4;
		end
	end

	// Stage 6: channel levels, and the luma divide by 1000 as a reciprocal
	// multiply on luma / 512 (nested floor divisions give the same quotient).
	function automatic logic [COLOR_W-1:0] chan_level(
		input logic signed [VAL_W-1:0] v,
		input logic                    analog
	);
		logic [COLOR_W-1:0] lvl;
		if (analog) begin
			if (v < 0) lvl = LEVEL_MIN;
			else if (v >= $signed(CH_SAT)) lvl = LEVEL_MAX;
			else lvl = v[16:9];
		end else begin
			lvl = (v > 0) ? LEVEL_MAX : LEVEL_MIN;
		end
		return lvl;
	endfunction

	level_t             lvl_s6;
	logic               luma_neg_s6, luma_sat_s6, luma_pos_s6;
	logic [QPROD_W-1:0] qprod_s6;
	logic [Q1_W-1:0]    q1;

	assign q1 = luma_s5[Q1_W+8:9];

	always_ff @(posedge clk) begin
		if (en_s6) begin
			lvl_s6.red   <= chan_level(val_s5.red, cfg.analog_mode);
			lvl_s6.green <= chan_level(val_s5.green, cfg.analog_mode);
			lvl_s6.blue  <= chan_level(val_s5.blue, cfg.analog_mode);
			luma_neg_s6  <= luma_s5 < 0;
			luma_pos_s6  <= luma_s5 > 0;
			luma_sat_s6  <= luma_s5 >= $signed(LUMA_SAT);
			qprod_s6     <= q1 * RECIP_1000;
		end
	end

	// Stage 7: gray level and the output register.
	level_t             lvl_s7;
	logic [COLOR_W-1:0] gray_s7;
	logic [COLOR_W-1:0] gray_d;

	always_comb begin
		if (cfg.analog_mode) begin
			if (luma_neg_s6) gray_d = LEVEL_MIN;
			else if (luma_sat_s6) gray_d = LEVEL_MAX;
			else gray_d = qprod_s6[RECIP_SHIFT+COLOR_W-1:RECIP_SHIFT];
		end else begin
			gray_d = luma_pos_s6 ? LEVEL_MAX : LEVEL_MIN;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			lvl_s7  <= lvl_s6;
			gray_s7 <= gray_d;
		end
	end

	assign levels.valid     = vld_s7;
	assign levels.out_red   = lvl_s7.red;
	assign levels.out_green = lvl_s7.green;
	assign levels.out_blue  = lvl_s7.blue;
	assign levels.out_gray  = gray_s7;
endmodule

@@ hw/rtl/lcm_checker.sv @@
// ----------------------------------------------------------------------------
// lcm_checker
// Port-level checks of the laser color mixer, bound to the top level.
// ----------------------------------------------------------------------------
module lcm_checker import lcm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COLOR_W-1:0] out_red,
	input logic [COLOR_W-1:0] out_green,
	input logic [COLOR_W-1:0] out_blue,
	input logic [COLOR_W-1:0] out_gray,
	input logic               cfg_we,
	input logic [IDX_W-1:0]   cfg_index,
	input logic [CFG_W-1:0]   cfg_data
);
	logic       mode_q;
	logic [3:0] inflight_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b1;
			inflight_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_ANALOG_MODE) mode_q <= cfg_data[0];
			inflight_q <= inflight_q + 4'(in_beat) - 4'(out_beat);
		end
	end

	// A waiting level beat holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_gray))
		else $error("level beat changed while stalled");

	// Every level beat stems from an accepted point.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 4'd0)
		else $error("level beat without a point in flight");

	// With the output side empty, the whole pipeline can take a point.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("points stalled while the output is empty");

	// In binary mode every level is fully off or fully on.
	a_binary_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mode_q |->
			(out_red == LEVEL_MIN || out_red == LEVEL_MAX)
			&& (out_green == LEVEL_MIN || out_green == LEVEL_MAX)
			&& (out_blue == LEVEL_MIN || out_blue == LEVEL_MAX)
			&& (out_gray == LEVEL_MIN || out_gray == LEVEL_MAX))
		else $error("binary mode level not 0 or 255");
endmodule

bind laser_color_mixer lcm_checker u_lcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (levels.valid),
	.out_ready (levels.ready),
	.out_red   (levels.out_red),
	.out_green (levels.out_green),
	.out_blue  (levels.out_blue),
	.out_gray  (levels.out_gray),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
